>>> hdl/rmr_pkg.sv
// ----------------------------------------------------------------------------
// rmr_pkg: shared types for the rational multiply and reduce block
// Payload structs, divider status and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package rmr_pkg;

  localparam int OPERAND_W = 16;
  localparam int RESULT_W  = 32;

  typedef struct packed {
    logic signed [OPERAND_W-1:0] first_num;
    logic signed [OPERAND_W-1:0] first_den;
    logic signed [OPERAND_W-1:0] second_num;
    logic signed [OPERAND_W-1:0] second_den;
  } rmr_in_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] prod_num;
    logic signed [RESULT_W-1:0] prod_den;
    logic                       zero_divisor;
  } rmr_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rmr_div_sts_t;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MULP = 10'b00_0000_0010,
    S_MULQ = 10'b00_0000_0100,
    S_LOAD = 10'b00_0000_1000,
    S_EUC  = 10'b00_0001_0000,
    S_REM  = 10'b00_0010_0000,
    S_QNUM = 10'b00_0100_0000,
    S_QDST = 10'b00_1000_0000,
    S_QDEN = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } rmr_state_t;

endpackage

`default_nettype wire

>>> hdl/rational_multiply_reduce.sv
// ----------------------------------------------------------------------------
// rational_multiply_reduce: product of two signed fractions in lowest terms
// Multiplies numerators and denominators, runs Euclid with truncating
// remainder on the two products and divides both by the resulting divisor.
// ----------------------------------------------------------------------------
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------
//   in      | in_valid/in_stall  | first_num first_den second_num second_den
//   out     | out_valid/out_stall| prod_num prod_den zero_divisor
//
// All divides share one bit-serial divider of W = 2*OPERAND_BITS bits: 32 at 16-bit operands.
// The input is stalled whenever the sequencer is not idle.
// Reset is synchronous and clears the sequencer, divider and output valid.
// A finished result waits in the output register while the next item runs;
// the one after that holds the sequencer in its last state until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_multiply_reduce #(
  parameter int OPERAND_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rmr_pkg::rmr_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rmr_pkg::rmr_out_t      out_data
);
  import rmr_pkg::*;

  localparam int N  = OPERAND_BITS;
  localparam int PW = 2 * N;
  localparam int EW = PW + RESULT_W;

  rmr_state_t state_r, state_nxt;

  logic signed [N-1:0]  fn_r, fd_r, sn_r, sd_r;
  logic signed [N-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] mul_out;
  logic signed [PW-1:0] p_r, q_r, a_r, b_r;
  logic signed [RESULT_W-1:0] num_r;
  logic         out_valid_r;
  rmr_out_t     out_data_r;

  logic          div_start;
  logic [PW-1:0] div_dvd, div_dvs, div_quo, div_rem;
  rmr_div_sts_t  div_sts;

  logic [PW-1:0] abs_a, abs_b, abs_p, abs_q;
  logic          b_zero, a_zero;
  logic          quo_neg;
  logic signed [PW-1:0] rem_s, quo_s;
  logic signed [EW-1:0] quo_e;
  logic          in_xfer, out_xfer;

  // operands: low N bits of the zero-extended field, read as signed
  function automatic logic signed [N-1:0] load_op(input logic [OPERAND_W-1:0] f);
    logic [RESULT_W-1:0] z;
    z = RESULT_W'(f);
    return z[N-1:0];
  endfunction

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  assign abs_a  = a_r[PW-1] ? PW'(-a_r) : PW'(a_r);
  assign abs_b  = b_r[PW-1] ? PW'(-b_r) : PW'(b_r);
  assign abs_p  = p_r[PW-1] ? PW'(-p_r) : PW'(p_r);
  assign abs_q  = q_r[PW-1] ? PW'(-q_r) : PW'(q_r);
  assign b_zero = (b_r == '0);
  assign a_zero = (a_r == '0);

  assign mul_a = (state_r == S_MULP) ? fn_r : fd_r;
  assign mul_b = (state_r == S_MULP) ? sn_r : sd_r;

  rmr_mul #(.N(N)) u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_out)
  );

  always_comb begin
    div_start = 1'b0;
    div_dvd   = abs_q;
    div_dvs   = abs_a;
    if (state_r == S_EUC) begin
      if (!b_zero) begin
        div_start = 1'b1;
        div_dvd   = abs_a;
        div_dvs   = abs_b;
      end else if (!a_zero) begin
        div_start = 1'b1;
        div_dvd   = abs_p;
      end
    end else if (state_r == S_QDST) begin
      div_start = 1'b1;
    end
  end

  rmr_div #(.W(PW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quo_r    (div_quo),
    .rem_r    (div_rem),
    .sts      (div_sts)
  );

  // remainder takes the dividend's sign; quotient the xor of both signs
  assign rem_s   = a_r[PW-1] ? PW'(-div_rem) : PW'(div_rem);
  assign quo_neg = ((state_r == S_QNUM) ? p_r[PW-1] : q_r[PW-1]) ^ a_r[PW-1];
  assign quo_s   = quo_neg ? PW'(-div_quo) : PW'(div_quo);
  assign quo_e   = EW'(quo_s);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_MULP;
      S_MULP: state_nxt = S_MULQ;
      S_MULQ: state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_EUC;
      S_EUC: begin
        if (!b_zero)      state_nxt = S_REM;
        else if (!a_zero) state_nxt = S_QNUM;
        else              state_nxt = S_DONE;
      end
      S_REM:  if (div_sts.done) state_nxt = S_EUC;
      S_QNUM: if (div_sts.done) state_nxt = S_QDST;
      S_QDST: state_nxt = S_QDEN;
      S_QDEN: if (div_sts.done) state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fn_r <= load_op(in_data.first_num);
      fd_r <= load_op(in_data.first_den);
      sn_r <= load_op(in_data.second_num);
      sd_r <= load_op(in_data.second_den);
    end
    if (state_r == S_MULQ) begin
      p_r <= mul_out;
    end
    if (state_r == S_LOAD) begin
      q_r <= mul_out;
      a_r <= p_r;
      b_r <= mul_out;
    end
    if (state_r == S_REM && div_sts.done) begin
      a_r <= b_r;
      b_r <= rem_s;
    end
    if (state_r == S_QNUM && div_sts.done) begin
      num_r <= quo_e[RESULT_W-1:0];
    end
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      if (a_zero) begin
        out_data_r.prod_num     <= '0;
        out_data_r.prod_den     <= '0;
        out_data_r.zero_divisor <= 1'b1;
      end else begin
        out_data_r.prod_num     <= num_r;
        out_data_r.prod_den     <= quo_e[RESULT_W-1:0];
        out_data_r.zero_divisor <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> hdl/rmr_mul.sv
// ----------------------------------------------------------------------------
// rmr_mul: registered signed multiplier
// Forms the full-width product of two signed operands, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmr_mul #(
  parameter int N = 16
) (
  input  wire logic                  clk,
  input  wire logic signed [N-1:0]   op_a,
  input  wire logic signed [N-1:0]   op_b,
  output logic signed [2*N-1:0]      prod_r
);

  localparam int PW = 2 * N;

  always_ff @(posedge clk) begin
    prod_r <= PW'(op_a) * PW'(op_b);
  end

endmodule

`default_nettype wire

>>> hdl/rmr_div.sv
// ----------------------------------------------------------------------------
// rmr_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmr_div #(
  parameter int W = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [W-1:0]  dividend,
  input  wire logic [W-1:0]  divisor,
  output logic [W-1:0]       quo_r,
  output logic [W-1:0]       rem_r,
  output rmr_pkg::rmr_div_sts_t sts
);
  import rmr_pkg::*;

  localparam int CW = $clog2(W);

  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    shifted;
  logic [W+1:0]  diff;
  logic          fits;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = !diff[W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // keep the partial remainder only when the divisor fits
      rem_r <= fits ? diff[W-1:0] : shifted[W-1:0];
      quo_r <= {quo_r[W-2:0], fits};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

>>> hdl/rmr_checker.sv
// ----------------------------------------------------------------------------
// rmr_checker: port-level checks for rational_multiply_reduce
// Watches the handshakes and the error encoding of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rmr_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire rmr_pkg::rmr_out_t out_data
);
  import rmr_pkg::*;

  // an accepted item occupies the block for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_zero_div_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_divisor |->
      out_data.prod_num == '0 && out_data.prod_den == '0)
    else $error("zero divisor result is not 0/0");

  // a result cannot appear in the cycle right after an item is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind rational_multiply_reduce rmr_checker u_rmr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
